>>> rtl/core/mck_pkg.sv
// ----------------------------------------------------------------------------
// mck_pkg
// Shared types, constants and character tables for the Morse character keyer.
// ----------------------------------------------------------------------------
package mck_pkg;

  localparam int CHAR_W     = 8;
  localparam int UNIT_W     = 12;
  localparam int DUR_W      = 15;
  localparam int PAT_W      = 8;
  localparam int IDX_W      = 3;

  localparam logic [UNIT_W-1:0] DOT_TICKS_RESET = 12'd100;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;

  // leading 1 marker, then elements MSB first: 1 = dash, 0 = dot
  localparam logic [PAT_W-1:0] LETTER_PAT [26] = '{
    8'd5,  8'd24, 8'd26, 8'd12, 8'd2,  8'd18, 8'd14, 8'd16, 8'd4,
    8'd23, 8'd13, 8'd20, 8'd7,  8'd6,  8'd15, 8'd22, 8'd29, 8'd10,
    8'd8,  8'd3,  8'd9,  8'd17, 8'd11, 8'd25, 8'd27, 8'd28
  };
  localparam logic [PAT_W-1:0] DIGIT_PAT [10] = '{
    8'd63, 8'd47, 8'd39, 8'd35, 8'd33, 8'd32, 8'd48, 8'd56, 8'd60, 8'd62
  };

  typedef enum logic [1:0] {
    SEG_GAP,    // off, 3 units (letter gap)
    SEG_ELEM,   // on, 1 or 3 units
    SEG_OFF,    // off, 1 unit
    SEG_SPACE   // off, 7 units (word gap)
  } seg_kind_t;

  typedef struct packed {
    logic      load;
    logic      push;
    seg_kind_t seg_kind;
    logic      seg_last;
    logic      set_gap;
    logic      clr_gap;
    logic      step_idx;
  } mck_cmd_t;

  typedef struct packed {
    logic is_sym;
    logic is_space;
    logic eot;
    logic gap_pending;
    logic idx_zero;
    logic out_free;
  } mck_status_t;

  function automatic logic [PAT_W-1:0] sym_pattern(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] ofs_l;
    logic [CHAR_W-1:0] ofs_d;
    logic [PAT_W-1:0]  pat;
    ofs_l = ch - CHAR_A;
    ofs_d = ch - CHAR_0;
    pat   = '0;
    if (ch >= CHAR_A && ch <= CHAR_Z) begin
      pat = LETTER_PAT[ofs_l[4:0]];
    end else if (ch >= CHAR_0 && ch <= CHAR_9) begin
      pat = DIGIT_PAT[ofs_d[3:0]];
    end
    return pat;
  endfunction

  // index of the first element below the marker bit
  function automatic logic [IDX_W-1:0] first_index(input logic [PAT_W-1:0] pat);
    logic [IDX_W-1:0] idx;
    idx = '0;
    priority if (pat[7]) idx = 3'd6;
    else if (pat[6])     idx = 3'd5;
    else if (pat[5])     idx = 3'd4;
    else if (pat[4])     idx = 3'd3;
    else if (pat[3])     idx = 3'd2;
    else if (pat[2])     idx = 3'd1;
    else                 idx = 3'd0;
    return idx;
  endfunction

endpackage

>>> rtl/core/mck_channels.sv
// ----------------------------------------------------------------------------
// mck channels
// Valid/ready channel interfaces: characters in, key segments out, unit config.
// ----------------------------------------------------------------------------
interface mck_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;
  modport source (output valid, char_code, end_of_text, input ready);
  modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface mck_seg_if;
  logic        valid;
  logic        ready;
  logic        key_on;
  logic [14:0] duration;
  logic        last;
  modport source (output valid, key_on, duration, last, input ready);
  modport sink   (input valid, key_on, duration, last, output ready);
endinterface

interface mck_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] dot_ticks;
  modport source (output valid, dot_ticks, input ready);
  modport sink   (input valid, dot_ticks, output ready);
endinterface

>>> rtl/core/morse_character_keyer.sv
// ----------------------------------------------------------------------------
// morse_character_keyer
// Turns ASCII characters into timed Morse key segments.
// ----------------------------------------------------------------------------
// One character is taken at a time on chars; A-Z and 0-9 become dot (on 1,
// off 1 unit) and dash (on 3, off 1) segments, a space gives a 7-unit word
// gap, and the 3-unit letter gap is emitted only ahead of the next symbol or
// when end_of_text is set. Other codes produce nothing. Segments leave on segs
// one beat per cycle while segs is ready, via a single output register; last
// marks the final beat of a character. After ST_IDLE loads a character and
// ST_DECIDE decodes it, up to 12 segments follow, one per cycle unless segs
// stalls. Write unit length on cfg while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module morse_character_keyer
  import mck_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mck_cfg_if.sink   cfg,
  mck_char_if.sink  chars,
  mck_seg_if.source segs
);

  mck_cmd_t    cmd;
  mck_status_t status;
  logic        in_ready;

  assign chars.ready = in_ready;

  mck_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chars.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mck_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .char_code   (chars.char_code),
    .end_of_text (chars.end_of_text),
    .cfg         (cfg),
    .segs        (segs),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

>>> rtl/core/mck_ctrl.sv
// ----------------------------------------------------------------------------
// mck_ctrl
// Sequencer: walks gap, elements, word gap and flush for one character.
// ----------------------------------------------------------------------------
module mck_ctrl
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  mck_status_t status,
  output mck_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_GAP,
    ST_ON,
    ST_OFF,
    ST_SPACE,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.seg_kind = SEG_OFF;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (status.is_sym) begin
          state_next = status.gap_pending ? ST_GAP : ST_ON;
        end else if (status.is_space) begin
          state_next = ST_SPACE;
        end else if (status.eot && status.gap_pending) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_GAP: begin
        if (status.out_free) begin
          cmd.push     = 1'b1;
          cmd.seg_kind = SEG_GAP;
          state_next   = ST_ON;
        end
      end
      ST_ON: begin
        if (status.out_free) begin
          cmd.push     = 1'b1;
          cmd.seg_kind = SEG_ELEM;
          state_next   = ST_OFF;
        end
      end
      ST_OFF: begin
        if (status.out_free) begin
          cmd.push     = 1'b1;
          cmd.seg_kind = SEG_OFF;
          if (status.idx_zero) begin
            // letter done: owe a letter gap, flush it now at end of text
            cmd.set_gap  = 1'b1;
            cmd.seg_last = !status.eot;
            state_next   = status.eot ? ST_FLUSH : ST_IDLE;
          end else begin
            cmd.step_idx = 1'b1;
            state_next   = ST_ON;
          end
        end
      end
      ST_SPACE: begin
        if (status.out_free) begin
          cmd.push     = 1'b1;
          cmd.seg_kind = SEG_SPACE;
          cmd.seg_last = 1'b1;
          cmd.clr_gap  = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.push     = 1'b1;
          cmd.seg_kind = SEG_GAP;
          cmd.seg_last = 1'b1;
          cmd.clr_gap  = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/mck_datapath.sv
// ----------------------------------------------------------------------------
// mck_datapath
// Character decode, element index, gap flag, unit register and output beat.
// ----------------------------------------------------------------------------
module mck_datapath
  import mck_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CHAR_W-1:0] char_code,
  input  logic              end_of_text,
  mck_cfg_if.sink           cfg,
  mck_seg_if.source         segs,
  input  mck_cmd_t          cmd,
  output mck_status_t       status
);

  logic [UNIT_W-1:0] dot_ticks;
  logic [PAT_W-1:0]  pat;
  logic [IDX_W-1:0]  idx;
  logic              is_sym;
  logic              is_space;
  logic              eot;
  logic              gap_pending;

  logic              out_valid;
  logic              out_key_on;
  logic [DUR_W-1:0]  out_duration;
  logic              out_last;

  logic [PAT_W-1:0]  in_pat;
  logic [UNIT_W-1:0] unit;
  logic [DUR_W-1:0]  dur1;
  logic [DUR_W-1:0]  dur3;
  logic [DUR_W-1:0]  dur7;
  logic [DUR_W-1:0]  seg_dur;

  assign cfg.ready = 1'b1;
  assign in_pat    = sym_pattern(char_code);

  // zero unit counts as one tick
  assign unit = (dot_ticks == '0) ? UNIT_W'(1) : dot_ticks;
  assign dur1 = DUR_W'(unit);
  assign dur3 = dur1 + (dur1 << 1);
  assign dur7 = (dur1 << 3) - dur1;

  always_comb begin
    unique case (cmd.seg_kind)
      SEG_GAP:   seg_dur = dur3;
      SEG_ELEM:  seg_dur = pat[idx] ? dur3 : dur1;
      SEG_OFF:   seg_dur = dur1;
      SEG_SPACE: seg_dur = dur7;
      default:   seg_dur = dur1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks   <= DOT_TICKS_RESET;
      gap_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        dot_ticks <= cfg.dot_ticks;
      end
      if (cmd.set_gap) begin
        gap_pending <= 1'b1;
      end else if (cmd.clr_gap) begin
        gap_pending <= 1'b0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (segs.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pat      <= in_pat;
      idx      <= first_index(in_pat);
      is_sym   <= (in_pat != '0);
      is_space <= (char_code == CHAR_SPACE);
      eot      <= end_of_text;
    end else if (cmd.step_idx) begin
      idx <= idx - IDX_W'(1);
    end
    if (cmd.push) begin
      out_key_on   <= (cmd.seg_kind == SEG_ELEM);
      out_duration <= seg_dur;
      out_last     <= cmd.seg_last;
    end
  end

  assign segs.valid    = out_valid;
  assign segs.key_on   = out_key_on;
  assign segs.duration = out_duration;
  assign segs.last     = out_last;

  assign status.is_sym      = is_sym;
  assign status.is_space    = is_space;
  assign status.eot         = eot;
  assign status.gap_pending = gap_pending;
  assign status.idx_zero    = (idx == '0);
  assign status.out_free    = !out_valid || segs.ready;

endmodule
